// ===== hdl/indexed_id_binary_search_macros.svh =====
// Assertion macros for the sorted ID table search checker.
`ifndef INDEXED_ID_BINARY_SEARCH_MACROS_SVH
`define INDEXED_ID_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IIBS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iibs check failed");

// Next-cycle implication, disabled during reset.
`define IIBS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iibs check failed");

`endif

// ===== hdl/iibs_pkg.sv =====
// Shared types and constants for the sorted ID table search block.
package iibs_pkg;

   localparam int ID_W    = 24;
   localparam int IDX_W   = 17;
   localparam int OFS_W   = 20;
   localparam int COUNT_W = 18;
   localparam int CSR_IDX_W = 2;

   localparam logic [ID_W-1:0]  HDR_MAGIC = 24'h300A01;
   localparam logic [OFS_W-1:0] REC_BASE  = 20'd9;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_WORD = 2'd1;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic [ID_W-1:0]    header_word;
   } cfg_type;

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

endpackage

// ===== hdl/iibs_mem.sv =====
// ID table: single-port-write, registered-read synchronous memory.
module iibs_mem #(
   parameter  int TABLE_DEPTH = 131072,
   localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         mem_we,
   input  logic [AW-1:0]                mem_waddr,
   input  logic [iibs_pkg::ID_W-1:0]    mem_wdata,
   input  logic                         mem_re,
   input  logic [AW-1:0]                mem_raddr,
   output logic [iibs_pkg::ID_W-1:0]    mem_rdata
);

   logic [iibs_pkg::ID_W-1:0] id_mem_ff [TABLE_DEPTH];
   logic [iibs_pkg::ID_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= id_mem_ff[mem_raddr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ===== hdl/iibs_ctrl.sv =====
// Command decode and binary search sequencer for the ID table.
module iibs_ctrl #(
   parameter  int TABLE_DEPTH = 131072,
   localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  iibs_pkg::cfg_type             cfg,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [iibs_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [iibs_pkg::ID_W-1:0]     req_key,
   output logic                          mem_we,
   output logic [AW-1:0]                 mem_waddr,
   output logic [iibs_pkg::ID_W-1:0]     mem_wdata,
   output logic                          mem_re,
   output logic [AW-1:0]                 mem_raddr,
   input  logic [iibs_pkg::ID_W-1:0]     mem_rdata,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [iibs_pkg::IDX_W-1:0]    rsp_match_index,
   output logic [iibs_pkg::OFS_W-1:0]    rsp_record_offset
);

   localparam int DW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (DW > iibs_pkg::COUNT_W) ? DW : iibs_pkg::COUNT_W;
   localparam int SW = CW + 1;
   localparam int OW = (CW > iibs_pkg::OFS_W) ? CW : iibs_pkg::OFS_W;

   iibs_pkg::state_type state_ff, state_in;

   logic signed [SW-1:0]       first_ff, first_in, last_ff, last_in;
   logic [CW-1:0]              mid_ff, mid_in;
   logic [iibs_pkg::ID_W-1:0]  key_ff, key_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [CW-1:0]              rsp_mid_ff, rsp_mid_in;

   logic                       accept;
   logic [CW-1:0]              count_ext, depth_c, count_sat, mid0;
   logic [CW-1:0]              idx_ext;
   logic                       hdr_ok;
   logic signed [SW-1:0]       mid_s, first_n, last_n;
   logic                       go_on;
   logic [CW:0]                sum_n;
   logic [OW-1:0]              mid_o;
   logic [iibs_pkg::OFS_W-1:0] mid20;

   assign accept    = start && !busy;
   assign busy      = (state_ff != iibs_pkg::ST_IDLE);
   assign count_ext = CW'(cfg.entry_count);
   assign depth_c   = CW'(TABLE_DEPTH);
   assign count_sat = (count_ext > depth_c) ? depth_c : count_ext;
   assign mid0      = (count_sat - CW'(1)) >> 1;
   assign hdr_ok    = (cfg.header_word == iibs_pkg::HDR_MAGIC);
   assign idx_ext   = CW'(req_entry_index);

   // Writes go straight to the table on acceptance.
   assign mem_we    = accept && (req_command == iibs_pkg::CMD_WRITE) && (idx_ext < depth_c);
   assign mem_waddr = idx_ext[AW-1:0];
   assign mem_wdata = req_key;

   // Narrowing of the probe range after a compare.
   assign mid_s = $signed({1'b0, mid_ff});
   always_comb begin
      first_n = first_ff;
      last_n  = last_ff;
      if (mem_rdata < key_ff) begin
         first_n = mid_s + SW'(1);
      end else begin
         last_n = mid_s - SW'(1);
      end
   end
   assign go_on = (first_n <= last_n);
   // Both bounds are non-negative whenever the search goes on.
   assign sum_n = {1'b0, first_n[CW-1:0]} + {1'b0, last_n[CW-1:0]};

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_mid_in   = '0;
      mem_re       = 1'b0;
      mem_raddr    = mid0[AW-1:0];
      unique case (state_ff)
         iibs_pkg::ST_IDLE: begin
            if (accept && (req_command == iibs_pkg::CMD_SEARCH)) begin
               if (!hdr_ok || (count_sat == '0)) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  mem_re   = 1'b1;
                  first_in = '0;
                  last_in  = $signed({1'b0, count_sat}) - SW'(1);
                  mid_in   = mid0;
                  key_in   = req_key;
                  state_in = iibs_pkg::ST_PROBE;
               end
            end
         end
         iibs_pkg::ST_PROBE: begin
            if (mem_rdata == key_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_mid_in   = mid_ff;
               state_in     = iibs_pkg::ST_IDLE;
            end else if (go_on) begin
               mem_re    = 1'b1;
               mem_raddr = sum_n[AW:1];
               first_in  = first_n;
               last_in   = last_n;
               mid_in    = sum_n[CW:1];
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = iibs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iibs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iibs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      last_ff      <= last_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      rsp_found_ff <= rsp_found_in;
      rsp_mid_ff   <= rsp_mid_in;
   end

   // Offset = index*6 + 9, kept to the field width.
   assign mid_o = OW'(rsp_mid_ff);
   assign mid20 = mid_o[iibs_pkg::OFS_W-1:0];

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_index   = rsp_mid_ff[iibs_pkg::IDX_W-1:0];
   assign rsp_record_offset = rsp_found_ff ?
                              ((mid20 << 2) + (mid20 << 1) + iibs_pkg::REC_BASE) : '0;

endmodule

// ===== hdl/indexed_id_binary_search.sv =====
// Top level: sorted ID table with binary search, CSR block and table memory.
//
// A write item (command 0) stores its key at entry_index in the cycle it is
// accepted and gives no result; busy stays low. A search item (command 1)
// gives one result on rsp_valid. With a bad header word or an entry count
// of zero the result comes the cycle after acceptance and busy stays low.
// Otherwise the search issues one table read per cycle from its single read
// port: P probes, P at most ceil(log2(count+1)) (18 for a full 131072-entry
// table), busy stays high while it probes, and the result strobes in the
// cycle after the last probe, in which a new item may already be
// accepted. Each result is shown for one cycle only and must be taken then.
// The table has no reset: only entries written before a search may be probed.
// CSR writes are always ready and take effect on the next cycle.
module indexed_id_binary_search #(
   parameter int TABLE_DEPTH = 131072
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic [iibs_pkg::IDX_W-1:0]       req_entry_index,
   input  logic [iibs_pkg::ID_W-1:0]        req_key,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [iibs_pkg::IDX_W-1:0]       rsp_match_index,
   output logic [iibs_pkg::OFS_W-1:0]       rsp_record_offset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [iibs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iibs_pkg::ID_W-1:0]        csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   iibs_pkg::cfg_type          cfg_ff, cfg_in;
   logic                       mem_we, mem_re;
   logic [AW-1:0]              mem_waddr, mem_raddr;
   logic [iibs_pkg::ID_W-1:0]  mem_wdata, mem_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            iibs_pkg::CSR_ENTRY_COUNT: cfg_in.entry_count = csr_wdata[iibs_pkg::COUNT_W-1:0];
            iibs_pkg::CSR_HEADER_WORD: cfg_in.header_word = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iibs_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_key           (req_key),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_re            (mem_re),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_match_index   (rsp_match_index),
      .rsp_record_offset (rsp_record_offset)
   );

   iibs_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

// ===== hdl/iibs_checker.sv =====
// Port-level checker for the sorted ID table search block, with its bind.
`include "indexed_id_binary_search_macros.svh"

module iibs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_found,
   input logic [iibs_pkg::IDX_W-1:0]    rsp_match_index,
   input logic [iibs_pkg::OFS_W-1:0]    rsp_record_offset
);

   logic rsp_zero;

   assign rsp_zero = (rsp_match_index == '0) && (rsp_record_offset == '0);

   // A miss carries zero index and offset.
   `IIBS_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_zero)

   // Every result traces back to an accepted item or a running search.
   `IIBS_ASSERT_IMP(a_rsp_has_item, clock, reset, rsp_valid, $past(start && !busy) || $past(busy))

   // A search only starts from an accepted item.
   `IIBS_ASSERT_IMP(a_busy_from_start, clock, reset, $rose(busy), $past(start))

   // A running search always ends with a result.
   `IIBS_ASSERT_IMP(a_end_has_rsp, clock, reset, $fell(busy) && !$past(reset), rsp_valid)

endmodule

bind indexed_id_binary_search iibs_checker u_iibs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_found         (rsp_found),
   .rsp_match_index   (rsp_match_index),
   .rsp_record_offset (rsp_record_offset)
);
